### hw/rtl/tsrb_pkg.sv
// Package for the tilt-shift row blend: shared widths, register codes,
// tanh lookup table and the control struct passed between pipeline parts.
// No dependencies.
`timescale 1ns / 1ps

package tsrb_pkg;

  localparam int unsigned ROW_W   = 11;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned DECAY_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // image height; rows at or above it clamp to the last row
  localparam int unsigned MAX_ROWS = 2048;

  // quotient bits below the 8.0 clamp (Q.12 argument, 15 bits)
  localparam int unsigned QUOT_W   = 15;
  localparam int unsigned FRAC_W   = 10;
  localparam int unsigned IDX_W    = QUOT_W - FRAC_W;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned TANH_W   = MAG_W + 1;
  localparam int unsigned LUT_DEPTH = 33;

  // diff stage + one stage per quotient bit + two interpolation stages
  localparam int unsigned TANH_LAT = QUOT_W + 3;

  localparam logic [MAG_W-1:0] TANH_ONE = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_START = 2'd0,
    REG_BAND_END   = 2'd1,
    REG_DECAY      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic neg;   // argument below the band edge
    logic zero;  // row on the band edge
    logic sat;   // argument at or beyond 8.0, or hard step
  } tanh_flags_t;

  typedef struct packed {
    logic en;     // whole pipeline advances
    logic valid;  // transaction entering
  } pipe_ctrl_t;

  localparam logic [MAG_W-1:0] TANH_LUT [LUT_DEPTH] = '{
    16'd0,     16'd8026,  16'd15143, 16'd20813, 16'd24956, 16'd27797,
    16'd29660, 16'd30847, 16'd31589, 16'd32048, 16'd32330, 16'd32501,
    16'd32606, 16'd32670, 16'd32708, 16'd32732, 16'd32746, 16'd32755,
    16'd32760, 16'd32763, 16'd32765, 16'd32766, 16'd32767, 16'd32767,
    16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
    16'd32768, 16'd32768, 16'd32768
  };

endpackage

### hw/rtl/tsrb_tanh.sv
// Pipelined signed tanh((row - band) / decay), 1.0 = 32768.
// Restoring divider, one quotient bit per stage, then table interpolation.
// Depends on tsrb_pkg.
`timescale 1ns / 1ps

module tsrb_tanh (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tsrb_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic [tsrb_pkg::ROW_W-1:0]           row_i,
  input  logic [tsrb_pkg::ROW_W-1:0]           band_i,
  input  logic [tsrb_pkg::DECAY_W-1:0]         decay_i,
  output logic                                 valid_o,
  output logic signed [tsrb_pkg::TANH_W-1:0]   tanh_o
);

  localparam int unsigned NS = tsrb_pkg::QUOT_W;
  localparam int unsigned DW = tsrb_pkg::DECAY_W;

  // stage 0: difference, magnitude, flags, initial remainder
  logic signed [tsrb_pkg::ROW_W:0] diff;
  logic [tsrb_pkg::ROW_W:0]        diff_abs;
  logic [tsrb_pkg::ROW_W-1:0]      mag;
  tsrb_pkg::tanh_flags_t           flags0;

  assign diff     = $signed({1'b0, row_i}) - $signed({1'b0, band_i});
  assign diff_abs = diff[tsrb_pkg::ROW_W] ? 12'(-diff) : 12'(diff);
  assign mag      = diff_abs[tsrb_pkg::ROW_W-1:0];
  assign flags0.neg  = diff[tsrb_pkg::ROW_W];
  assign flags0.zero = (diff == '0);
  // q >= 2^15 exactly when mag*32 >= decay; covers decay == 0 too
  assign flags0.sat  = ({mag, 5'b0} >= decay_i);

  logic                  vld_q  [NS+1];
  logic [DW-1:0]         rem_q  [NS+1];
  logic [NS-1:0]         quot_q [NS+1];
  tsrb_pkg::tanh_flags_t flg_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctrl_i.en) begin
      vld_q[0] <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      rem_q[0]  <= {mag, 5'b0};
      quot_q[0] <= '0;
      flg_q[0]  <= flags0;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_div
    logic [DW:0] rem_sh;
    logic [DW:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_q[i-1], 1'b0};
    assign ge      = (rem_sh >= {1'b0, decay_i});
    assign rem_sub = rem_sh - {1'b0, decay_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q[i]  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quot_q[i] <= {quot_q[i-1][NS-2:0], ge};
        flg_q[i]  <= flg_q[i-1];
      end
    end
  end

  // interpolation: multiply stage
  logic [tsrb_pkg::IDX_W-1:0]  idx;
  logic [tsrb_pkg::FRAC_W-1:0] frac;
  logic [tsrb_pkg::IDX_W:0]    idx_hi;
  logic [tsrb_pkg::MAG_W-1:0]  lo;
  logic [tsrb_pkg::MAG_W-1:0]  hi;
  logic [13:0]                 step;
  logic [23:0]                 prod;

  assign idx    = quot_q[NS][NS-1:tsrb_pkg::FRAC_W];
  assign frac   = quot_q[NS][tsrb_pkg::FRAC_W-1:0];
  assign idx_hi = {1'b0, idx} + 6'd1;
  assign lo     = tsrb_pkg::TANH_LUT[{1'b0, idx}];
  assign hi     = tsrb_pkg::TANH_LUT[idx_hi];
  assign step   = 14'(hi - lo);
  assign prod   = 24'(step) * 24'(frac);

  logic                       b_vld_q;
  logic [tsrb_pkg::MAG_W-1:0] b_lo_q;
  logic [23:0]                b_prod_q;
  tsrb_pkg::tanh_flags_t      b_flg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      b_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      b_lo_q   <= lo;
      b_prod_q <= prod;
      b_flg_q  <= flg_q[NS];
    end
  end

  // interpolation: round, apply sign and special cases
  logic [23:0]                 rnd;
  logic [tsrb_pkg::MAG_W-1:0]  interp;
  logic [tsrb_pkg::MAG_W-1:0]  mag_v;
  logic signed [tsrb_pkg::TANH_W-1:0] tanh_d;

  assign rnd    = (b_prod_q + 24'd512) >> tsrb_pkg::FRAC_W;
  assign interp = b_lo_q + rnd[tsrb_pkg::MAG_W-1:0];
  assign mag_v  = b_flg_q.sat ? tsrb_pkg::TANH_ONE : interp;

  always_comb begin
    priority if (b_flg_q.zero) begin
      tanh_d = '0;
    end else if (b_flg_q.neg) begin
      tanh_d = -$signed({1'b0, mag_v});
    end else begin
      tanh_d = $signed({1'b0, mag_v});
    end
  end

  logic                                c_vld_q;
  logic signed [tsrb_pkg::TANH_W-1:0]  c_tanh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      c_tanh_q <= tanh_d;
    end
  end

  assign valid_o = c_vld_q;
  assign tanh_o  = c_tanh_q;

endmodule

### hw/rtl/tsrb_blend.sv
// Blend back end: alpha from two tanh values, weighted mix, round, clamp.
// Three register stages, the last is the output register. Depends on tsrb_pkg.
`timescale 1ns / 1ps

module tsrb_blend (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsrb_pkg::pipe_ctrl_t                ctrl_i,
  input  logic signed [tsrb_pkg::TANH_W-1:0]  t_rise_i,
  input  logic signed [tsrb_pkg::TANH_W-1:0]  t_fall_i,
  input  logic [tsrb_pkg::PIX_W-1:0]          base_i,
  input  logic [tsrb_pkg::PIX_W-1:0]          over_i,
  output logic                                valid_o,
  output logic [tsrb_pkg::PIX_W-1:0]          pixel_o
);

  // stage 1: alpha = floor((t1 - t2) / 2), saturated to Q1.15
  logic signed [17:0] s;
  logic signed [17:0] half;
  logic signed [15:0] alpha;

  assign s    = 18'(t_rise_i) - 18'(t_fall_i);
  assign half = s >>> 1;
  assign alpha = (half > 18'sd32767) ? 16'sh7fff : 16'(half);

  logic                       a_vld_q;
  logic signed [15:0]         a_alpha_q;
  logic [tsrb_pkg::PIX_W-1:0] a_base_q;
  logic [tsrb_pkg::PIX_W-1:0] a_over_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      a_vld_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      a_alpha_q <= alpha;
      a_base_q  <= base_i;
      a_over_q  <= over_i;
    end
  end

  // stage 2: alpha * (overlay - base)
  logic signed [8:0]  dpix;
  logic signed [24:0] mix;

  assign dpix = $signed({1'b0, a_over_q}) - $signed({1'b0, a_base_q});
  assign mix  = 25'(a_alpha_q) * 25'(dpix);

  logic                       m_vld_q;
  logic signed [24:0]         m_mix_q;
  logic [tsrb_pkg::PIX_W-1:0] m_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      m_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      m_mix_q  <= mix;
      m_base_q <= a_base_q;
    end
  end

  // stage 3: add base, round, clamp to 0..255
  logic signed [25:0]         acc;
  logic [9:0]                 acc_sh;
  logic [tsrb_pkg::PIX_W-1:0] pix_d;

  assign acc    = $signed({1'b0, m_base_q, 15'b0}) + 26'(m_mix_q) + 26'sd16384;
  assign acc_sh = acc[24:15];

  always_comb begin
    priority if (acc[25]) begin
      pix_d = '0;
    end else if (acc_sh > 10'd255) begin
      pix_d = '1;
    end else begin
      pix_d = acc_sh[tsrb_pkg::PIX_W-1:0];
    end
  end

  logic                       o_vld_q;
  logic [tsrb_pkg::PIX_W-1:0] o_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      o_pix_q <= pix_d;
    end
  end

  assign valid_o = o_vld_q;
  assign pixel_o = o_pix_q;

endmodule

### hw/rtl/tilt_shift_row_blend.sv
// Top level of the tilt-shift row blend: config registers, row clamp,
// two tanh pipelines, pixel delay line and blend back end.
// Depends on tsrb_pkg, tsrb_tanh, tsrb_blend.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one pixel transaction:
//    row index, base pixel and overlay pixel. Output channel
//    (out_valid_o / out_ready_i) returns exactly one blended pixel each.
//  - Config channel (cfg_valid_i / cfg_ready_o) writes band_start (0),
//    band_end (1) or decay (2, Q8.8); index 3 is ignored. cfg_ready_o is
//    always high. Write only while no pixel is in flight.
//  - Pipeline: 21 register stages (1 diff stage, 15 divider stages of one
//    quotient bit each, 2 interpolation stages, 3 blend stages, the last
//    one being the output register).
//  - Throughput: one pixel per clock while not stalled; the pipeline depth
//    is set by the one-bit-per-stage restoring divider for (row - edge) / decay.
//  - Stall: when out_valid_o is high and out_ready_i low, the whole pipeline
//    freezes and in_ready_o drops; nothing is lost or repeated.
//  - Reset: all stage valid bits clear, config registers return to 0 (hard
//    step with an empty band, i.e. output equals the base pixel).
`timescale 1ns / 1ps

module tilt_shift_row_blend #(
  parameter int unsigned MAX_ROWS = tsrb_pkg::MAX_ROWS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsrb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsrb_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // pixel input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tsrb_pkg::ROW_W-1:0]       row_i,
  input  logic [tsrb_pkg::PIX_W-1:0]       base_pixel_i,
  input  logic [tsrb_pkg::PIX_W-1:0]       overlay_pixel_i,
  // pixel output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tsrb_pkg::PIX_W-1:0]       out_pixel_o
);

  localparam int unsigned LAT = tsrb_pkg::TANH_LAT;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [tsrb_pkg::ROW_W-1:0]   band_start_q;
  logic [tsrb_pkg::ROW_W-1:0]   band_end_q;
  logic [tsrb_pkg::DECAY_W-1:0] decay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_start_q <= '0;
      band_end_q   <= '0;
      decay_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (tsrb_pkg::reg_idx_e'(cfg_index_i))
        tsrb_pkg::REG_BAND_START: band_start_q <= cfg_data_i[tsrb_pkg::ROW_W-1:0];
        tsrb_pkg::REG_BAND_END:   band_end_q   <= cfg_data_i[tsrb_pkg::ROW_W-1:0];
        tsrb_pkg::REG_DECAY:      decay_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: one global advance, frozen only by a held result
  // ---------------------------------------------------------------------
  logic                 adv;
  tsrb_pkg::pipe_ctrl_t front_ctrl;
  tsrb_pkg::pipe_ctrl_t back_ctrl;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign front_ctrl.en    = adv;
  assign front_ctrl.valid = in_valid_i;

  // rows at or past the image height saturate to the last row
  logic [16:0]                row_ext;
  logic [tsrb_pkg::ROW_W-1:0] row_cl;

  assign row_ext = {6'b0, row_i};
  assign row_cl  = (32'(row_ext) >= MAX_ROWS) ? tsrb_pkg::ROW_W'(MAX_ROWS - 1) : row_i;

  // ---------------------------------------------------------------------
  // tanh pipelines for the rising and falling band edges
  // ---------------------------------------------------------------------
  logic                                rise_vld;
  logic                                fall_vld;
  logic signed [tsrb_pkg::TANH_W-1:0]  t_rise;
  logic signed [tsrb_pkg::TANH_W-1:0]  t_fall;

  tsrb_tanh u_tanh_rise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (front_ctrl),
    .row_i   (row_cl),
    .band_i  (band_start_q),
    .decay_i (decay_q),
    .valid_o (rise_vld),
    .tanh_o  (t_rise)
  );

  tsrb_tanh u_tanh_fall (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (front_ctrl),
    .row_i   (row_cl),
    .band_i  (band_end_q),
    .decay_i (decay_q),
    .valid_o (fall_vld),
    .tanh_o  (t_fall)
  );

  // ---------------------------------------------------------------------
  // Pixel delay line, aligned with the tanh pipelines
  // ---------------------------------------------------------------------
  logic [tsrb_pkg::PIX_W-1:0] base_dl_q [LAT];
  logic [tsrb_pkg::PIX_W-1:0] over_dl_q [LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      base_dl_q[0] <= base_pixel_i;
      over_dl_q[0] <= overlay_pixel_i;
      for (int i = 1; i < LAT; i++) begin
        base_dl_q[i] <= base_dl_q[i-1];
        over_dl_q[i] <= over_dl_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Blend back end
  // ---------------------------------------------------------------------
  assign back_ctrl.en    = adv;
  assign back_ctrl.valid = rise_vld;

  tsrb_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (back_ctrl),
    .t_rise_i (t_rise),
    .t_fall_i (t_fall),
    .base_i   (base_dl_q[LAT-1]),
    .over_i   (over_dl_q[LAT-1]),
    .valid_o  (out_valid_o),
    .pixel_o  (out_pixel_o)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tanh_vld_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rise_vld == fall_vld)
    else $error("tanh pipelines out of step");

  a_tanh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rise_vld |-> (t_rise <= 17'sd32768) && (t_rise >= -17'sd32768))
    else $error("tanh out of range");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(rise_vld) && $stable(t_rise))
    else $error("pipeline moved while stalled");

  a_row_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_cl) < MAX_ROWS)
    else $error("row clamp failed");

endmodule

### test/tilt_shift_row_blend_test.sv
// Self-checking testbench for tilt_shift_row_blend: a queue-fed driver, a
// monitor and an in-bench predictor of the tanh band weight and pixel blend.
// Depends on tsrb_pkg and the tilt_shift_row_blend RTL.
`timescale 1ns / 1ps

module tilt_shift_row_blend_test;

  localparam int unsigned ROWS_MAX = tsrb_pkg::MAX_ROWS;
  localparam int unsigned PIPE_LAT = 21;
  // index with no register behind it
  localparam logic [tsrb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [tsrb_pkg::ROW_W-1:0] row;
    logic [tsrb_pkg::PIX_W-1:0] base;
    logic [tsrb_pkg::PIX_W-1:0] over;
  } pixel_txn_t;

  // blend weight table, tanh(k/4) in Q.15
  localparam int unsigned TANH_Q15 [33] = '{
    0, 8026, 15143, 20813, 24956, 27797, 29660, 30847, 31589, 32048, 32330,
    32501, 32606, 32670, 32708, 32732, 32746, 32755, 32760, 32763, 32765,
    32766, 32767, 32767, 32768, 32768, 32768, 32768, 32768, 32768, 32768,
    32768, 32768};

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [tsrb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tsrb_pkg::CFG_DAT_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [tsrb_pkg::ROW_W-1:0] row;
  logic [tsrb_pkg::PIX_W-1:0] base_pix, over_pix, out_pix;

  // predictor copy of the registers
  logic [tsrb_pkg::ROW_W-1:0]   edge_lo_q, edge_hi_q;
  logic [tsrb_pkg::DECAY_W-1:0] decay_q;

  pixel_txn_t pending_px[$];
  logic [tsrb_pkg::PIX_W-1:0] expected_px[$];
  int unsigned err_count;
  bit drv_hold;      // sender paused by the stimulus process
  int hold_rx;       // receiver hold-off cycles remaining
  bit rx_stall_tgl;  // flipped by the stimulus to start a hold-off
  bit rx_stall_seen;
  bit calm;          // stretch with no idling
  logic [tsrb_pkg::CFG_IDX_W-1:0] wr_idx;
  logic [tsrb_pkg::CFG_DAT_W-1:0] wr_dat;
  bit wr_req;
  logic in_ready_seen;
  logic cfg_taken;
  pixel_txn_t drv_txn;

  tilt_shift_row_blend dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .row_i(row), .base_pixel_i(base_pix), .overlay_pixel_i(over_pix),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_pixel_o(out_pix)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // signed tanh of diff/decay, 1.0 = 32768
  function automatic int tanh_q15(int diff, int unsigned dec);
    longint unsigned q;
    int unsigned mag, k, f, v;
    if (diff == 0) return 0;
    mag = (diff < 0) ? -diff : diff;
    if (dec == 0) begin
      v = 32768;
    end else begin
      q = (longint'(mag) << 20) / dec;
      if (q > 32768) q = 32768;
      k = 32'(q >> 10);
      f = 32'(q & 1023);
      if (k >= 32) v = TANH_Q15[32];
      else v = TANH_Q15[k] + (((TANH_Q15[k+1] - TANH_Q15[k]) * f + 512) >> 10);
    end
    return (diff < 0) ? -int'(v) : int'(v);
  endfunction

  function automatic logic [tsrb_pkg::PIX_W-1:0] blend_pixel(pixel_txn_t t);
    int r, s, alpha;
    longint v;
    r = int'(t.row);
    if (r >= ROWS_MAX) r = ROWS_MAX - 1;
    s = tanh_q15(r - int'(edge_lo_q), 32'(decay_q))
        - tanh_q15(r - int'(edge_hi_q), 32'(decay_q));
    alpha = ((s + 65536) >>> 1) - 32768;
    if (alpha > 32767) alpha = 32767;
    if (alpha < -32768) alpha = -32768;
    v = longint'(t.base) * 32768 + longint'(alpha) * (longint'(t.over) - longint'(t.base))
        + 16384;
    if (v < 0) v = 0;
    v = v / 32768;
    if (v > 255) v = 255;
    return v[tsrb_pkg::PIX_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Pixel driver: inputs change at the falling edge. The handshake is read
  // back from the rising edge that just passed; one decision per edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      row <= '0; base_pix <= '0; over_pix <= '0;
    end else if (!in_valid || in_ready_seen) begin
      if (!drv_hold && pending_px.size() > 0 &&
          (calm || $urandom_range(99) >= 17)) begin
        drv_txn = pending_px.pop_front();
        row <= drv_txn.row; base_pix <= drv_txn.base; over_pix <= drv_txn.over;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // Config driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    end else if (cfg_valid && cfg_taken) cfg_valid <= 1'b0;
    else if (wr_req && !cfg_valid) begin
      cfg_index <= wr_idx; cfg_data <= wr_dat; cfg_valid <= 1'b1;
    end
  end
  always @(posedge clk) cfg_taken <= cfg_valid && cfg_ready;

  // Receiver idling and hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_stall_tgl != rx_stall_seen) begin
      rx_stall_seen <= rx_stall_tgl;
      hold_rx <= 300;
      out_ready <= 1'b0;
    end else if (hold_rx > 0) begin
      out_ready <= 1'b0;
      hold_rx <= hold_rx - 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // Monitor: accepts on both sides at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      edge_lo_q <= '0; edge_hi_q <= '0; decay_q <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_px.push_back(blend_pixel(pixel_txn_t'{row, base_pix, over_pix}));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsrb_pkg::REG_BAND_START: edge_lo_q <= cfg_data[tsrb_pkg::ROW_W-1:0];
          tsrb_pkg::REG_BAND_END:   edge_hi_q <= cfg_data[tsrb_pkg::ROW_W-1:0];
          tsrb_pkg::REG_DECAY:      decay_q   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          report_mismatch($sformatf("unexpected out_pixel %0d", out_pix));
        end else begin
          logic [tsrb_pkg::PIX_W-1:0] e;
          e = expected_px.pop_front();
          if (out_pix !== e)
            report_mismatch($sformatf("out_pixel %0d, expected %0d", out_pix, e));
        end
      end
    end
  end

  task automatic write_reg(logic [tsrb_pkg::CFG_IDX_W-1:0] idx,
                           logic [tsrb_pkg::CFG_DAT_W-1:0] dat);
    @(negedge clk);
    wr_idx = idx; wr_dat = dat; wr_req = 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    wr_req = 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_px.size() > 0 || in_valid || expected_px.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic add_px(int r, int b, int o);
    pixel_txn_t t;
    t.row = tsrb_pkg::ROW_W'(r); t.base = tsrb_pkg::PIX_W'(b);
    t.over = tsrb_pkg::PIX_W'(o);
    pending_px.push_back(t);
  endtask

  task automatic set_band(int lo, int hi, int dec);
    write_reg(tsrb_pkg::REG_BAND_START, tsrb_pkg::CFG_DAT_W'(lo));
    write_reg(tsrb_pkg::REG_BAND_END, tsrb_pkg::CFG_DAT_W'(hi));
    write_reg(tsrb_pkg::REG_DECAY, tsrb_pkg::CFG_DAT_W'(dec));
  endtask

  // random items, mostly near the band edges
  task automatic add_random(int n, int lo, int hi);
    int r;
    repeat (n) begin
      case ($urandom_range(3))
        0: r = $urandom_range(2047);
        1: r = lo + int'($urandom_range(80)) - 40;
        2: r = hi + int'($urandom_range(80)) - 40;
        default: r = $urandom_range(1) ? lo : hi;
      endcase
      if (r < 0) r = 0;
      if (r > 2047) r = 2047;
      add_px(r, $urandom_range(255), $urandom_range(255));
    end
  endtask

  initial begin
    int lo, hi, dec;
    rst_n = 1'b0;
    calm = 0; drv_hold = 0; wr_req = 0; wr_idx = '0; wr_dat = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: reset registers (output equals base), pixel extremes
    add_px(0, 0, 255); add_px(2047, 255, 0); add_px(5, 200, 17);
    drain();
    // hard step band, edges exactly hit, the top row
    set_band(100, 200, 0);
    add_px(99, 10, 250); add_px(100, 10, 250); add_px(150, 10, 250);
    add_px(200, 10, 250); add_px(201, 10, 250); add_px(2047, 255, 255);
    drain();
    // inverted band: negative weight, saturation at both ends
    set_band(1500, 300, 256);
    add_px(800, 255, 0); add_px(800, 0, 255); add_px(300, 128, 64);
    add_px(1500, 3, 250);
    drain();
    // widest and narrowest smooth transitions, extreme edges
    set_band(0, 2047, 16'hFFFF);
    add_px(0, 0, 255); add_px(1024, 0, 255); add_px(2047, 255, 0);
    drain();
    set_band(2047, 0, 1);
    add_px(1, 255, 0); add_px(1024, 85, 170); add_px(2046, 1, 254);
    drain();
    write_reg(CFG_IDX_SPARE, 16'hFFFF);   // unused index, ignored
    add_px(1000, 100, 200);
    drain();

    // random phases with new settings each time
    calm = 1;
    set_band(600, 900, 16'h1000);
    add_random(150, 600, 900);
    drain();
    calm = 0;
    for (int ph = 0; ph < 8; ph++) begin
      lo = $urandom_range(2047); hi = $urandom_range(2047);
      case ($urandom_range(3))
        0: dec = 0;
        1: dec = $urandom_range(65535);
        default: dec = $urandom_range(8191);
      endcase
      set_band(lo, hi, dec);
      if (ph == 3) rx_stall_tgl = ~rx_stall_tgl;   // fill the pipeline, stall the input
      add_random(140, lo, hi);
      if (ph == 5) begin
        while (pending_px.size() > 70) @(posedge clk);
        drv_hold = 1;                // sender waits for every result
        while (in_valid || expected_px.size() > 0) @(posedge clk);
        @(negedge clk) drv_hold = 0;
      end
      drain();
    end

    if (err_count == 0) begin
      $display("tilt_shift_row_blend_test: done, clean");
    end else begin
      $display("tilt_shift_row_blend_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tilt_shift_row_blend_test: done, errors");
    $finish;
  end

endmodule

### sim.f
hw/rtl/tsrb_pkg.sv
hw/rtl/tsrb_tanh.sv
hw/rtl/tsrb_blend.sv
hw/rtl/tilt_shift_row_blend.sv
test/tilt_shift_row_blend_test.sv
